// File: rtl/necir_pkg.sv
// Shared types, register indexes and constants of the NEC IR frame decoder.
package necir_pkg;

   // Frame layout
   localparam int FRAME_BITS = 32;
   localparam int WORD_W     = 32;
   localparam int CNT_W      = $clog2(FRAME_BITS + 1);
   localparam int DUR_W      = 16;
   localparam int DUR100_W   = 23;
   localparam int PROD_W     = 24;
   localparam int TOL_W      = 7;

   // Configuration register indexes; the first six double as window indexes
   localparam int NUM_REGS   = 7;
   localparam int NUM_WIN    = 6;
   localparam int IDX_W      = 3;
   localparam logic [IDX_W-1:0] REG_HDR_MARK  = 3'd0;
   localparam logic [IDX_W-1:0] REG_HDR_SPACE = 3'd1;
   localparam logic [IDX_W-1:0] REG_BIT_MARK  = 3'd2;
   localparam logic [IDX_W-1:0] REG_ONE_SPACE = 3'd3;
   localparam logic [IDX_W-1:0] REG_ZERO_SPACE = 3'd4;
   localparam logic [IDX_W-1:0] REG_END_MARK  = 3'd5;
   localparam logic [IDX_W-1:0] REG_TOLERANCE = 3'd6;

   // Reset values of the expected lengths and of the tolerance
   localparam logic [DUR_W-1:0] EXP_RESET [NUM_WIN] = '{
      16'd9000, 16'd4500, 16'd560, 16'd1690, 16'd560, 16'd560
   };
   localparam logic [TOL_W-1:0] TOL_RESET = 7'd20;
   localparam logic [TOL_W-1:0] TOL_MAX   = 7'd99;
   localparam logic [7:0]       PCT_SCALE = 8'd100;

   // Frame status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_BAD_BIT = 2'd1;
   localparam logic [1:0] STAT_BAD_END = 2'd2;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Classified segment: its level and one in-window flag per expected length
   typedef struct packed {
      logic               level;
      logic [NUM_WIN-1:0] win;
   } seg_class_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HDR_SPACE,
      PH_BIT_MARK,
      PH_BIT_SPACE,
      PH_END_MARK
   } phase_type;

endpackage

// File: rtl/nec_ir_frame_decoder.sv
// Top level of the NEC IR frame decoder: front classifier, queue and frame back end.
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_ready  req_seg_level, req_duration_us
//  rsp      out        rsp_valid / rsp_ready  rsp_command_word, rsp_frame_status
//  csr      in         csr_we                 csr_index, csr_wdata
//
// One item per cycle sustained while the queue has room. An item is registered at
// the input, classified against all six windows into a four-entry queue, and then
// stepped through the frame state machine; a result goes from the queue head into
// the output register. Register writes update the window bounds in the same edge.
// Reset (synchronous) restores the default timings and empties all stages. A stalled
// result stops the back end only for an item with a result; the queue then fills.
module nec_ir_frame_decoder (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [necir_pkg::IDX_W-1:0]       csr_index,
   input  logic [necir_pkg::DUR_W-1:0]       csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_seg_level,
   input  logic [necir_pkg::DUR_W-1:0]       req_duration_us,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [necir_pkg::WORD_W-1:0]      rsp_command_word,
   output logic [1:0]                        rsp_frame_status
);

   logic                     q_push;
   logic                     q_full;
   logic                     q_pop;
   logic                     q_not_empty;
   necir_pkg::seg_class_type q_in;
   necir_pkg::seg_class_type q_head;

   necir_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_seg_level   (req_seg_level),
      .req_duration_us (req_duration_us),
      .q_push          (q_push),
      .q_data          (q_in),
      .q_full          (q_full)
   );

   necir_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   necir_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_not_empty      (q_not_empty),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_command_word (rsp_command_word),
      .rsp_frame_status (rsp_frame_status)
   );

endmodule

// File: rtl/necir_front.sv
// Front part: configuration registers, window bounds, input stage and segment classification.
module necir_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [necir_pkg::IDX_W-1:0]           csr_index,
   input  logic [necir_pkg::DUR_W-1:0]           csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_seg_level,
   input  logic [necir_pkg::DUR_W-1:0]           req_duration_us,
   output logic                                  q_push,
   output necir_pkg::seg_class_type              q_data,
   input  logic                                  q_full
);

   logic [necir_pkg::DUR_W-1:0]    exp_ff [necir_pkg::NUM_WIN];
   logic [necir_pkg::DUR_W-1:0]    exp_in [necir_pkg::NUM_WIN];
   logic [necir_pkg::TOL_W-1:0]    tol_ff;
   logic [necir_pkg::TOL_W-1:0]    tol_in;
   logic [necir_pkg::TOL_W-1:0]    tol_clamp;
   logic [7:0]                     lo_fac;
   logic [7:0]                     hi_fac;
   logic [necir_pkg::PROD_W-1:0]   lo_prod_ff [necir_pkg::NUM_WIN];
   logic [necir_pkg::PROD_W-1:0]   lo_prod_in [necir_pkg::NUM_WIN];
   logic [necir_pkg::PROD_W-1:0]   hi_prod_ff [necir_pkg::NUM_WIN];
   logic [necir_pkg::PROD_W-1:0]   hi_prod_in [necir_pkg::NUM_WIN];
   logic                           s1_valid_ff;
   logic                           s1_valid_in;
   logic                           s1_level_ff;
   logic [necir_pkg::DUR100_W-1:0] s1_dur100_ff;
   logic [necir_pkg::DUR100_W-1:0] dur100;
   logic [necir_pkg::PROD_W-1:0]   dur_lo_cmp;
   logic [necir_pkg::PROD_W-1:0]   dur_hi_cmp;

   // Take register writes; the bounds follow in the same edge
   always_comb begin
      for (int i = 0; i < necir_pkg::NUM_WIN; i++) begin
         if (reset) begin
            exp_in[i] = necir_pkg::EXP_RESET[i];
         end else if (csr_we && (csr_index == necir_pkg::IDX_W'(i))) begin
            exp_in[i] = csr_wdata;
         end else begin
            exp_in[i] = exp_ff[i];
         end
      end
      if (reset) begin
         tol_in = necir_pkg::TOL_RESET;
      end else if (csr_we && (csr_index == necir_pkg::REG_TOLERANCE)) begin
         tol_in = csr_wdata[necir_pkg::TOL_W-1:0];
      end else begin
         tol_in = tol_ff;
      end
   end

   // Scale each expected length by (100 - tol) and (100 + tol)
   always_comb begin
      tol_clamp = (tol_in > necir_pkg::TOL_MAX) ? necir_pkg::TOL_MAX : tol_in;
      lo_fac    = necir_pkg::PCT_SCALE - {1'b0, tol_clamp};
      hi_fac    = necir_pkg::PCT_SCALE + {1'b0, tol_clamp};
      for (int i = 0; i < necir_pkg::NUM_WIN; i++) begin
         lo_prod_in[i] = necir_pkg::PROD_W'(exp_in[i]) * necir_pkg::PROD_W'(lo_fac);
         hi_prod_in[i] = necir_pkg::PROD_W'(exp_in[i]) * necir_pkg::PROD_W'(hi_fac);
      end
   end

   always_ff @(posedge clock) begin
      exp_ff     <= exp_in;
      tol_ff     <= tol_in;
      lo_prod_ff <= lo_prod_in;
      hi_prod_ff <= hi_prod_in;
   end

   // Input stage: hold an item while the queue is full
   assign req_ready = !s1_valid_ff || !q_full;
   assign q_push    = s1_valid_ff && !q_full;

   always_comb begin
      s1_valid_in = req_ready ? req_valid : s1_valid_ff;
      dur100 = ({7'd0, req_duration_us} << 6) + ({7'd0, req_duration_us} << 5)
             + ({7'd0, req_duration_us} << 2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_level_ff  <= req_seg_level;
         s1_dur100_ff <= dur100;
      end
   end

   // Classify: lo <= dur*100 + 99 and dur*100 <= hi, against each window
   always_comb begin
      dur_hi_cmp   = {1'b0, s1_dur100_ff};
      dur_lo_cmp   = dur_hi_cmp + necir_pkg::PROD_W'(99);
      q_data.level = s1_level_ff;
      for (int i = 0; i < necir_pkg::NUM_WIN; i++) begin
         q_data.win[i] = (lo_prod_ff[i] <= dur_lo_cmp) && (dur_hi_cmp <= hi_prod_ff[i]);
      end
   end

endmodule

// File: rtl/necir_queue.sv
// Short queue of classified segments between front and back.
module necir_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  necir_pkg::seg_class_type push_data,
   output logic                     full,
   input  logic                     pop,
   output logic                     not_empty,
   output necir_pkg::seg_class_type head
);

   necir_pkg::seg_class_type          slot_ff [necir_pkg::QUEUE_DEPTH];
   logic [necir_pkg::QPTR_W-1:0]      wr_ptr_ff;
   logic [necir_pkg::QPTR_W-1:0]      wr_ptr_in;
   logic [necir_pkg::QPTR_W-1:0]      rd_ptr_ff;
   logic [necir_pkg::QPTR_W-1:0]      rd_ptr_in;
   logic [necir_pkg::QCNT_W-1:0]      count_ff;
   logic [necir_pkg::QCNT_W-1:0]      count_in;

   assign full      = (count_ff == necir_pkg::QCNT_W'(necir_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = push ? necir_pkg::QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? necir_pkg::QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = necir_pkg::QCNT_W'(count_ff + necir_pkg::QCNT_W'(push)
                                             - necir_pkg::QCNT_W'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/necir_back.sv
// Back part: frame state machine, bit collection and result register.
module necir_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_not_empty,
   input  necir_pkg::seg_class_type          q_head,
   output logic                              q_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [necir_pkg::WORD_W-1:0]      rsp_command_word,
   output logic [1:0]                        rsp_frame_status
);

   necir_pkg::phase_type             phase_ff;
   necir_pkg::phase_type             phase_in;
   logic [necir_pkg::CNT_W-1:0]      bit_idx_ff;
   logic [necir_pkg::CNT_W-1:0]      bit_idx_in;
   logic [necir_pkg::WORD_W-1:0]     shift_ff;
   logic [necir_pkg::WORD_W-1:0]     shift_in;
   logic [necir_pkg::WORD_W-1:0]     bit_onehot;
   logic                             last_bit;
   logic                             is_one;
   logic                             is_zero;
   logic                             emit;
   logic [necir_pkg::WORD_W-1:0]     emit_word;
   logic [1:0]                       emit_status;
   logic                             out_free;
   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   logic [necir_pkg::WORD_W-1:0]     rsp_word_ff;
   logic [1:0]                       rsp_status_ff;

   assign last_bit = (bit_idx_ff == necir_pkg::CNT_W'(necir_pkg::FRAME_BITS - 1));
   assign is_one   = q_head.win[necir_pkg::REG_ONE_SPACE];
   assign is_zero  = q_head.win[necir_pkg::REG_ZERO_SPACE];

   // Next phase from the classified segment at the queue head
   always_comb begin
      case (phase_ff)
         necir_pkg::PH_IDLE: begin
            phase_in = (!q_head.level && q_head.win[necir_pkg::REG_HDR_MARK])
                     ? necir_pkg::PH_HDR_SPACE : necir_pkg::PH_IDLE;
         end
         necir_pkg::PH_HDR_SPACE: begin
            phase_in = (q_head.level && q_head.win[necir_pkg::REG_HDR_SPACE])
                     ? necir_pkg::PH_BIT_MARK : necir_pkg::PH_IDLE;
         end
         necir_pkg::PH_BIT_MARK: begin
            phase_in = (!q_head.level && q_head.win[necir_pkg::REG_BIT_MARK])
                     ? necir_pkg::PH_BIT_SPACE : necir_pkg::PH_IDLE;
         end
         necir_pkg::PH_BIT_SPACE: begin
            if (q_head.level && (is_one || is_zero)) begin
               phase_in = last_bit ? necir_pkg::PH_END_MARK : necir_pkg::PH_BIT_MARK;
            end else begin
               phase_in = necir_pkg::PH_IDLE;
            end
         end
         default: begin
            phase_in = necir_pkg::PH_IDLE;
         end
      endcase
   end

   // Bit one-hot for positions that fit in the word; later bits are only timed
   always_comb begin
      for (int i = 0; i < necir_pkg::WORD_W; i++) begin
         bit_onehot[i] = (32'(bit_idx_ff) == i);
      end
   end

   // Result, bit counter and collected word
   always_comb begin
      emit        = 1'b0;
      emit_word   = '0;
      emit_status = necir_pkg::STAT_OK;
      bit_idx_in  = bit_idx_ff;
      shift_in    = shift_ff;
      case (phase_ff)
         necir_pkg::PH_BIT_MARK: begin
            if (!q_head.level && !q_head.win[necir_pkg::REG_BIT_MARK]) begin
               emit        = 1'b1;
               emit_status = necir_pkg::STAT_BAD_BIT;
            end
         end
         necir_pkg::PH_BIT_SPACE: begin
            if (q_head.level && !is_one && !is_zero) begin
               emit        = 1'b1;
               emit_status = necir_pkg::STAT_BAD_BIT;
            end
            bit_idx_in = necir_pkg::CNT_W'(bit_idx_ff + 1'b1);
            if (is_one) begin
               shift_in = shift_ff | bit_onehot;
            end
         end
         necir_pkg::PH_END_MARK: begin
            if (!q_head.level) begin
               emit        = 1'b1;
               emit_word   = shift_ff;
               emit_status = q_head.win[necir_pkg::REG_END_MARK]
                           ? necir_pkg::STAT_OK : necir_pkg::STAT_BAD_END;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
      // Drop the collected frame whenever the machine falls back to idle or enters the header space
      if (phase_in == necir_pkg::PH_IDLE || phase_in == necir_pkg::PH_HDR_SPACE) begin
         bit_idx_in = '0;
         shift_in   = '0;
      end
   end

   // Take the head unless it has a result and the output register is still full
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign q_pop    = q_not_empty && (!emit || out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= necir_pkg::PH_IDLE;
         bit_idx_ff <= '0;
         shift_ff   <= '0;
      end else if (q_pop) begin
         phase_ff   <= phase_in;
         bit_idx_ff <= bit_idx_in;
         shift_ff   <= shift_in;
      end
   end

   // Output register
   always_comb begin
      if (q_pop && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && emit) begin
         rsp_word_ff   <= emit_word;
         rsp_status_ff <= emit_status;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_command_word = rsp_word_ff;
   assign rsp_frame_status = rsp_status_ff;

   // Results come only from the data and end phases
   a_emit_phase: assert property (@(posedge clock) disable iff (reset)
      (q_pop && emit) |-> (phase_ff == necir_pkg::PH_BIT_MARK ||
                           phase_ff == necir_pkg::PH_BIT_SPACE ||
                           phase_ff == necir_pkg::PH_END_MARK))
      else $error("result emitted outside a data or end phase");

   // Idle holds no partial frame
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == necir_pkg::PH_IDLE) |-> (bit_idx_ff == '0 && shift_ff == '0))
      else $error("idle with leftover frame state");

   // The end phase is reached only after a full frame of bits
   a_end_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == necir_pkg::PH_END_MARK)
         |-> (bit_idx_ff == necir_pkg::CNT_W'(necir_pkg::FRAME_BITS)))
      else $error("end mark awaited with wrong bit count");

   // A new result appears only after an item that caused one
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(q_pop && emit))
      else $error("result without a causing item");

endmodule

// File: dv/tb_nec_ir_frame_decoder.sv
// Self-checking testbench for the NEC IR frame decoder: segment driver, result monitor.
`timescale 1ns / 100ps

module tb_nec_ir_frame_decoder;
   import necir_pkg::*;

   localparam int unsigned DUR_MAX     = (1 << DUR_W) - 1;
   localparam int unsigned SEGS_FRAME  = 2 * FRAME_BITS + 3;
   localparam int unsigned DRAIN_CYCLES = 16;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

   typedef struct {
      logic             level;
      logic [DUR_W-1:0] dur;
   } seg_item_t;

   typedef struct {
      logic [WORD_W-1:0] word;
      logic [1:0]        status;
   } frame_result_t;

   typedef enum int {
      FAULT_NONE,
      FAULT_HDR_MARK,
      FAULT_HDR_SPACE,
      FAULT_BIT_MARK,
      FAULT_BIT_SPACE,
      FAULT_END_MARK,
      FAULT_LEVEL
   } frame_fault_e;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_we = 1'b0;
   logic [IDX_W-1:0]    csr_index = '0;
   logic [DUR_W-1:0]    csr_wdata = '0;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_seg_level = 1'b0;
   logic [DUR_W-1:0]    req_duration_us = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [WORD_W-1:0]   rsp_command_word;
   logic [1:0]          rsp_frame_status;

   // Timing registers as the decoder should hold them
   logic [DUR_W-1:0]    win_len [NUM_WIN];
   logic [TOL_W-1:0]    tol_pct;

   // Frame tracking state of the predictor
   phase_type           fr_phase;
   int unsigned         fr_bits;
   logic [WORD_W-1:0]   fr_word;

   seg_item_t           segment_queue [$];
   frame_result_t       pending_frames [$];
   seg_item_t           next_seg;
   frame_result_t       want;
   int unsigned         seg_count = 0;
   int unsigned         mismatch_count = 0;
   int unsigned         cycle_count = 0;
   int unsigned         send_idle_pct = 0;
   int unsigned         recv_stall_pct = 0;
   logic                steady_run = 1'b0;

   nec_ir_frame_decoder DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_seg_level    (req_seg_level),
      .req_duration_us  (req_duration_us),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_command_word (rsp_command_word),
      .rsp_frame_status (rsp_frame_status)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic void window_bounds(input logic [DUR_W-1:0] nominal,
                                         output int unsigned lo, output int unsigned hi);
      int unsigned tol;
      int unsigned scale;
      int unsigned n;
      tol   = (tol_pct > TOL_MAX) ? TOL_MAX : tol_pct;
      scale = PCT_SCALE;
      n     = nominal;
      lo    = (n * (scale - tol)) / scale;
      hi    = (n * (scale + tol)) / scale;
   endfunction

   function automatic bit dur_in_window(input logic [DUR_W-1:0] dur,
                                        input logic [DUR_W-1:0] nominal);
      int unsigned lo;
      int unsigned hi;
      window_bounds(nominal, lo, hi);
      return (dur >= lo) && (dur <= hi);
   endfunction

   function automatic void frame_idle();
      fr_phase = PH_IDLE;
      fr_bits  = 0;
      fr_word  = '0;
   endfunction

   function automatic void record_frame(input logic [WORD_W-1:0] word, input logic [1:0] status);
      frame_result_t r;
      r.word   = word;
      r.status = status;
      pending_frames.push_back(r);
      frame_idle();
   endfunction

   // Advance the frame state by one accepted segment
   function automatic void decode_segment(input logic level, input logic [DUR_W-1:0] dur);
      case (fr_phase)
         PH_IDLE: begin
            if (!level && dur_in_window(dur, win_len[REG_HDR_MARK])) begin
               fr_bits  = 0;
               fr_word  = '0;
               fr_phase = PH_HDR_SPACE;
            end
         end
         PH_HDR_SPACE: begin
            if (level && dur_in_window(dur, win_len[REG_HDR_SPACE]))
               fr_phase = PH_BIT_MARK;
            else
               frame_idle();
         end
         PH_BIT_MARK: begin
            if (level)
               frame_idle();
            else if (!dur_in_window(dur, win_len[REG_BIT_MARK]))
               record_frame('0, STAT_BAD_BIT);
            else
               fr_phase = PH_BIT_SPACE;
         end
         PH_BIT_SPACE: begin
            if (!level) begin
               frame_idle();
            end else if (dur_in_window(dur, win_len[REG_ONE_SPACE]) ||
                         dur_in_window(dur, win_len[REG_ZERO_SPACE])) begin
               // one window wins when both match
               if (dur_in_window(dur, win_len[REG_ONE_SPACE]) && fr_bits < WORD_W)
                  fr_word[fr_bits] = 1'b1;
               fr_bits++;
               fr_phase = (fr_bits >= FRAME_BITS) ? PH_END_MARK : PH_BIT_MARK;
            end else begin
               record_frame('0, STAT_BAD_BIT);
            end
         end
         PH_END_MARK: begin
            if (level)
               frame_idle();
            else
               record_frame(fr_word, dur_in_window(dur, win_len[REG_END_MARK]) ?
                            STAT_OK : STAT_BAD_END);
         end
         default: frame_idle();
      endcase
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic bit roll(input int unsigned pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   // Pick a length inside the window, edges favored
   function automatic logic [DUR_W-1:0] dur_near(input logic [DUR_W-1:0] nominal);
      int unsigned lo;
      int unsigned hi;
      window_bounds(nominal, lo, hi);
      if (hi > DUR_MAX) hi = DUR_MAX;
      case ($urandom_range(0, 3))
         0:       return DUR_W'(lo);
         1:       return DUR_W'(hi);
         default: return DUR_W'($urandom_range(hi, lo));
      endcase
   endfunction

   // Pick a length outside the window where one exists
   function automatic logic [DUR_W-1:0] dur_off(input logic [DUR_W-1:0] nominal);
      int unsigned lo;
      int unsigned hi;
      window_bounds(nominal, lo, hi);
      if (lo > 0 && (hi >= DUR_MAX || $urandom_range(0, 1)))
         return $urandom_range(0, 1) ? DUR_W'(lo - 1) : DUR_W'($urandom_range(lo - 1, 0));
      if (hi < DUR_MAX)
         return $urandom_range(0, 1) ? DUR_W'(hi + 1) : DUR_W'($urandom_range(DUR_MAX, hi + 1));
      return DUR_W'($urandom_range(DUR_MAX, 0));
   endfunction

   task automatic push_seg(input logic level, input logic [DUR_W-1:0] dur);
      seg_item_t s;
      s.level = level;
      s.dur   = dur;
      segment_queue.push_back(s);
      seg_count++;
   endtask

   // Queue one frame, optionally with one broken segment
   task automatic push_frame(input frame_fault_e fault);
      logic [WORD_W-1:0] word;
      logic [DUR_W-1:0]  nominal;
      logic              level;
      int unsigned       spot;
      int                flip_at;
      int unsigned       bit_no;
      bit                bad;
      case ($urandom_range(0, 7))
         0:       word = '0;
         1:       word = '1;
         default: word = $urandom;
      endcase
      spot    = $urandom_range(0, FRAME_BITS - 1);
      flip_at = (fault == FAULT_LEVEL) ? int'($urandom_range(0, SEGS_FRAME - 1)) : -1;
      for (int k = 0; k < SEGS_FRAME; k++) begin
         bit_no = (k - 2) / 2;
         if (k == 0) begin
            level = 1'b0; nominal = win_len[REG_HDR_MARK]; bad = (fault == FAULT_HDR_MARK);
         end else if (k == 1) begin
            level = 1'b1; nominal = win_len[REG_HDR_SPACE]; bad = (fault == FAULT_HDR_SPACE);
         end else if (k == SEGS_FRAME - 1) begin
            level = 1'b0; nominal = win_len[REG_END_MARK]; bad = (fault == FAULT_END_MARK);
         end else if (k % 2 == 0) begin
            level = 1'b0; nominal = win_len[REG_BIT_MARK];
            bad = (fault == FAULT_BIT_MARK) && (bit_no == spot);
         end else begin
            level   = 1'b1;
            nominal = word[bit_no] ? win_len[REG_ONE_SPACE] : win_len[REG_ZERO_SPACE];
            bad     = (fault == FAULT_BIT_SPACE) && (bit_no == spot);
         end
         if (k == flip_at) level = ~level;
         push_seg(level, bad ? dur_off(nominal) : dur_near(nominal));
         // cut some broken frames short, let others run on as trailing junk
         if ((bad || k == flip_at) && $urandom_range(0, 1)) break;
      end
   endtask

   task automatic push_noise();
      int unsigned n;
      n = $urandom_range(1, 6);
      repeat (n) begin
         if ($urandom_range(0, 2) == 0)
            push_seg(1'($urandom), dur_near(win_len[$urandom_range(0, NUM_WIN - 1)]));
         else
            push_seg(1'($urandom), DUR_W'($urandom));
      end
   endtask

   // Hold until every item is taken and every frame result has come back
   task automatic wait_drained();
      while (segment_queue.size() != 0 || req_valid || pending_frames.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [IDX_W-1:0] idx, input logic [DUR_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_HDR_MARK, REG_HDR_SPACE, REG_BIT_MARK,
         REG_ONE_SPACE, REG_ZERO_SPACE, REG_END_MARK: win_len[idx] = val;
         REG_TOLERANCE: tol_pct = val[TOL_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_timing(input logic [DUR_W-1:0] hdr_mark, input logic [DUR_W-1:0] hdr_space,
                              input logic [DUR_W-1:0] bit_mark, input logic [DUR_W-1:0] one_space,
                              input logic [DUR_W-1:0] zero_space, input logic [DUR_W-1:0] end_mark,
                              input logic [DUR_W-1:0] tol);
      write_csr(REG_HDR_MARK, hdr_mark);
      write_csr(REG_HDR_SPACE, hdr_space);
      write_csr(REG_BIT_MARK, bit_mark);
      write_csr(REG_ONE_SPACE, one_space);
      write_csr(REG_ZERO_SPACE, zero_space);
      write_csr(REG_END_MARK, end_mark);
      write_csr(REG_TOLERANCE, tol);
      // out-of-range index must leave everything alone
      write_csr(REG_UNUSED, DUR_W'($urandom));
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic run_phase(input int unsigned budget);
      int unsigned start;
      int unsigned frames;
      int unsigned pick;
      start  = seg_count;
      frames = 0;
      @(negedge clock);
      while (seg_count - start < budget || frames < 6) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            push_frame(FAULT_NONE);
            frames++;
         end else if (pick < 90) begin
            push_frame(frame_fault_e'($urandom_range(FAULT_HDR_MARK, FAULT_LEVEL)));
            frames++;
         end else begin
            push_noise();
         end
      end
      wait_drained();
   endtask

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            decode_segment(req_seg_level, req_duration_us);
         // advance to the next item once the current one is gone
         if (!req_valid || req_ready) begin
            if (segment_queue.size() != 0 && (steady_run || !roll(send_idle_pct))) begin
               next_seg         = segment_queue.pop_front();
               req_valid       <= 1'b1;
               req_seg_level   <= next_seg.level;
               req_duration_us <= next_seg.dur;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_frames.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected result word=%h status=%0d", $realtime,
                           rsp_command_word, rsp_frame_status);
            end else begin
               want = pending_frames.pop_front();
               if (rsp_command_word !== want.word || rsp_frame_status !== want.status) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: result mismatch word exp=%h got=%h status exp=%0d got=%0d",
                              $realtime, want.word, rsp_command_word, want.status,
                              rsp_frame_status);
               end
            end
         end
         rsp_ready <= steady_run || !roll(recv_stall_pct);
      end
   end

   // Cycle limit and stretches without idling
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if ($urandom_range(0, 149) == 0) steady_run <= ~steady_run;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL nec_ir_frame_decoder");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      for (int i = 0; i < NUM_WIN; i++) win_len[i] = EXP_RESET[i];
      tol_pct = TOL_RESET;
      frame_idle();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct  = 10;
      recv_stall_pct = 88;

      // Directed cases at reset timing
      push_seg(1'b1, 16'd9000);                           // space while idle: ignored
      push_seg(1'b0, 16'd0);                              // shortest mark
      push_seg(1'b0, 16'hFFFF);                           // saturated mark
      push_seg(1'b0, 16'd7200); push_seg(1'b1, 16'd3599); // bad header space
      push_seg(1'b0, 16'd10800); push_seg(1'b0, 16'd4500); // mark where space due
      push_seg(1'b0, 16'd9000); push_seg(1'b1, 16'd4500);
      push_seg(1'b1, 16'd560);                            // space where bit mark due
      push_seg(1'b0, 16'd9000); push_seg(1'b1, 16'd4500);
      push_seg(1'b0, 16'd1000);                           // bad bit mark
      push_seg(1'b0, 16'd9000); push_seg(1'b1, 16'd4500);
      push_seg(1'b0, 16'd560); push_seg(1'b1, 16'd1000);  // bad bit space
      push_seg(1'b0, 16'd9000); push_seg(1'b1, 16'd4500);
      push_seg(1'b0, 16'd560); push_seg(1'b0, 16'd560);   // mark where bit space due
      wait_drained();

      run_phase(250);

      // exact match only
      load_timing(16'd9000, 16'd4500, 16'd560, 16'd1690, 16'd560, 16'd560, 16'd0);
      run_phase(300);

      send_idle_pct  = 88;
      recv_stall_pct = 10;

      // longest lengths, tolerance field overflowing past the cap
      load_timing(16'hFFFF, 16'hFFFF, DUR_W'($urandom_range(1500, 200)),
                  DUR_W'($urandom_range(4000, 200)), DUR_W'($urandom_range(4000, 200)),
                  16'hFFFF, 16'hFFFF);
      run_phase(300);

      load_timing(DUR_W'($urandom_range(4000, 100)), DUR_W'($urandom_range(4000, 100)),
                  DUR_W'($urandom_range(4000, 100)), DUR_W'($urandom_range(4000, 100)),
                  DUR_W'($urandom_range(4000, 100)), DUR_W'($urandom_range(4000, 100)),
                  DUR_W'($urandom_range(40, 0)));
      run_phase(300);

      send_idle_pct  = 0;
      recv_stall_pct = 0;

      load_timing(DUR_W'($urandom), DUR_W'($urandom), DUR_W'($urandom), DUR_W'($urandom),
                  DUR_W'($urandom), DUR_W'($urandom), DUR_W'($urandom));
      run_phase(300);

      // widest windows at nominal timing
      load_timing(16'd9000, 16'd4500, 16'd560, 16'd1690, 16'd560, 16'd560, 16'd99);
      run_phase(300);

      if (mismatch_count == 0 && pending_frames.size() == 0)
         $display("PASS nec_ir_frame_decoder");
      else
         $display("FAIL nec_ir_frame_decoder");
      $finish;
   end

endmodule

// File: files.f
rtl/necir_pkg.sv
rtl/necir_front.sv
rtl/necir_queue.sv
rtl/necir_back.sv
rtl/nec_ir_frame_decoder.sv
dv/tb_nec_ir_frame_decoder.sv
